/* design/blr_pkg.sv */
// Package: shared constants for the line rasterizer.
`default_nettype none

package blr_pkg;

   // Default coordinate width in bits (two's complement).
   localparam int unsigned COORD_BITS_DEFAULT = 6;

endpackage : blr_pkg

`default_nettype wire

/* design/bresenham_line_rasterizer.sv */
// Top level: sequential midpoint line rasterizer with one shared decision adder.
// An accepted segment passes the setup and prep states before its first cell is registered.
// Throughput: one cell per cycle while rsp_ready is high; a segment covers at most
//    2^COORD_BITS cells (64 at 6-bit coordinates), one segment walked at a time,
//    as the single decision adder produces one cell per cycle.
// The next segment is taken while the last cell may still wait in the output register.
// Reset (synchronous, active high) returns to idle and drops any pending result.
`default_nettype none

module bresenham_line_rasterizer #(
   parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // segment transaction
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   // cell transaction
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_cell_x,
   output logic signed [COORD_BITS-1:0]      rsp_cell_y,
   output logic                              rsp_last_cell
);

   import blr_pkg::*;

   localparam int unsigned W  = COORD_BITS;
   localparam int unsigned DW = COORD_BITS + 3;   // decision term and increments

   typedef enum logic [1:0] {
      ST_IDLE,    // wait for a segment
      ST_SETUP,   // pick major axis, order endpoints
      ST_PREP,    // spans, increments, initial decision term
      ST_RUN      // emit one cell per cycle while the output register is free
   } state_type;

   state_type state_ff;

   // captured endpoints
   logic signed [W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   // ordered segment
   logic                steep_ff;
   logic signed [W-1:0] maj0_ff, maj1_ff, min0_ff, min1_ff;

   // walk state
   logic signed [W-1:0]  maj_ff, min_ff;
   logic                 step_neg_ff;
   logic signed [DW-1:0] dec_ff, inc_lo_ff, inc_hi_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [W-1:0]  cell_x_ff, cell_y_ff;
   logic                 last_ff;

   // ---------------- setup: major axis and endpoint order ----------------
   logic signed [W:0]   dx, dy;
   logic        [W:0]   adx, ady;
   logic                steep_in;
   logic signed [W-1:0] a_maj, a_min, b_maj, b_min;
   logic                swap;

   always_comb begin
      dx       = {ex_ff[W-1], ex_ff} - {sx_ff[W-1], sx_ff};
      dy       = {ey_ff[W-1], ey_ff} - {sy_ff[W-1], sy_ff};
      adx      = dx[W] ? $unsigned(-dx) : $unsigned(dx);
      ady      = dy[W] ? $unsigned(-dy) : $unsigned(dy);
      // equal spans keep x as the major axis
      steep_in = ady > adx;
      a_maj    = steep_in ? sy_ff : sx_ff;
      a_min    = steep_in ? sx_ff : sy_ff;
      b_maj    = steep_in ? ey_ff : ex_ff;
      b_min    = steep_in ? ex_ff : ey_ff;
      // walk with the major coordinate rising
      swap     = a_maj > b_maj;
   end

   // ---------------- prep: spans and decision increments ----------------
   logic signed [W:0]    dmaj_s, dmin_s;
   logic        [W:0]    dmaj, dmin;
   logic signed [DW-1:0] two_dmin, two_dmaj, dmaj_ext;

   always_comb begin
      dmaj_s   = {maj1_ff[W-1], maj1_ff} - {maj0_ff[W-1], maj0_ff};
      dmin_s   = {min1_ff[W-1], min1_ff} - {min0_ff[W-1], min0_ff};
      dmaj     = $unsigned(dmaj_s);
      dmin     = dmin_s[W] ? $unsigned(-dmin_s) : $unsigned(dmin_s);
      two_dmin = $signed({1'b0, dmin, 1'b0});
      two_dmaj = $signed({1'b0, dmaj, 1'b0});
      dmaj_ext = $signed({2'b00, dmaj});
   end

   // ---------------- run: shared decision adder ----------------
   logic                 load;       // output register free for the next cell
   logic                 at_end;
   logic                 dec_neg;
   logic signed [DW-1:0] dec_in;
   logic signed [W-1:0]  min_in;
   logic                 rsp_valid_in;

   always_comb begin
      load    = !rsp_valid_ff || rsp_ready;
      at_end  = maj_ff == maj1_ff;
      dec_neg = dec_ff[DW-1];
      // one adder, the increment chosen by the sign of the decision term
      dec_in  = dec_ff + (dec_neg ? inc_lo_ff : inc_hi_ff);
      min_in  = dec_neg ? min_ff : (step_neg_ff ? min_ff - 1'b1 : min_ff + 1'b1);
      // load a new cell, else hold an untaken one, else drop the taken one
      rsp_valid_in = (state_ff == ST_RUN && load) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sx_ff    <= req_start_x;
                  sy_ff    <= req_start_y;
                  ex_ff    <= req_end_x;
                  ey_ff    <= req_end_y;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               steep_ff <= steep_in;
               maj0_ff  <= swap ? b_maj : a_maj;
               min0_ff  <= swap ? b_min : a_min;
               maj1_ff  <= swap ? a_maj : b_maj;
               min1_ff  <= swap ? a_min : b_min;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               maj_ff      <= maj0_ff;
               min_ff      <= min0_ff;
               step_neg_ff <= !(min0_ff < min1_ff);
               dec_ff      <= two_dmin - dmaj_ext;
               inc_lo_ff   <= two_dmin;
               inc_hi_ff   <= two_dmin - two_dmaj;
               state_ff    <= ST_RUN;
            end
            ST_RUN: begin
               // advance one cell whenever the output register is free
               if (load) begin
                  cell_x_ff    <= steep_ff ? min_ff : maj_ff;
                  cell_y_ff    <= steep_ff ? maj_ff : min_ff;
                  last_ff      <= at_end;
                  maj_ff       <= maj_ff + 1'b1;
                  min_ff       <= min_in;
                  dec_ff       <= dec_in;
                  if (at_end) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready     = state_ff == ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_x    = cell_x_ff;
   assign rsp_cell_y    = cell_y_ff;
   assign rsp_last_cell = last_ff;

   // ---------------- assertions ----------------
   a_accept_to_setup : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SETUP)
      else $error("accepted segment did not enter setup");

   a_walk_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> maj_ff <= maj1_ff)
      else $error("major coordinate walked past the end point");

   a_last_ends_walk : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && load && at_end |=> state_ff == ST_IDLE && rsp_valid && rsp_last_cell)
      else $error("final cell did not close the segment");

   a_no_early_last : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && load && !at_end |=> state_ff == ST_RUN && !rsp_last_cell)
      else $error("last flag raised before the final cell");

endmodule : bresenham_line_rasterizer

`default_nettype wire

/* dv/bresenham_line_rasterizer_tb.sv */
// Testbench for the line rasterizer: segment stimulus, cell predictor and scoreboard.
`default_nettype none

module bresenham_line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB           = blr_pkg::COORD_BITS_DEFAULT;
   localparam int COORD_MIN    = -(1 << (CB - 1));
   localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
   localparam int RANDOM_SEGS  = 200;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PRINT_CAP    = 40;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      is_last;
   } cell_type;

   // Receiver back-pressure styles; each runs for a random stretch of cycles.
   typedef enum int {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_THROTTLE
   } drain_mode_type;

   // Segment-to-cell predictor plus in-order comparison of emitted cells.
   class cell_scoreboard_type;
      cell_type expected_cells[$];
      int       mismatches;
      int       segments;
      int       cells_checked;
      int       steep_segs;
      int       reversed_segs;
      int       single_cells;

      function int pending();
         return expected_cells.size();
      endfunction

      function int span(int v);
         return (v < 0) ? -v : v;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, what);
      endtask

      function void note_segment(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
         int       maj0, min0, maj1, min1, swap_tmp;
         int       dmaj, dmin, err, dir, mj, mn;
         bit       steep;
         cell_type c;
         steep = span(int'(ey) - int'(sy)) > span(int'(ex) - int'(ex - ex + sx));
         if (steep) begin
            maj0 = sy; min0 = sx; maj1 = ey; min1 = ex;
         end else begin
            maj0 = sx; min0 = sy; maj1 = ex; min1 = ey;
         end
         // walk the major axis upward: swap endpoints when it runs backward
         if (maj0 > maj1) begin
            swap_tmp = maj0; maj0 = maj1; maj1 = swap_tmp;
            swap_tmp = min0; min0 = min1; min1 = swap_tmp;
            reversed_segs++;
         end
         dmaj = maj1 - maj0;
         dmin = span(min1 - min0);
         err  = 2 * dmin - dmaj;
         dir  = (min0 < min1) ? 1 : -1;
         mn   = min0;
         for (mj = maj0; mj <= maj1; mj++) begin
            c.x       = steep ? coord_type'(mn) : coord_type'(mj);
            c.y       = steep ? coord_type'(mj) : coord_type'(mn);
            c.is_last = (mj == maj1);
            expected_cells.insert(expected_cells.size(), c);
            if (err < 0) begin
               err += 2 * dmin;
            end else begin
               mn  += dir;
               err += 2 * dmin - 2 * dmaj;
            end
         end
         segments++;
         if (steep) steep_segs++;
         if (dmaj == 0) single_cells++;
      endfunction

      task check_cell(coord_type x, coord_type y, logic is_last);
         cell_type want;
         cells_checked++;
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected cell (%0d,%0d) last=%0b", x, y, is_last));
         end else begin
            want = expected_cells.pop_front();
            if (x !== want.x)
               report_mismatch($sformatf("cell_x %0d, expected %0d", x, want.x));
            if (y !== want.y)
               report_mismatch($sformatf("cell_y %0d, expected %0d", y, want.y));
            if (is_last !== want.is_last)
               report_mismatch($sformatf("last_cell %0b, expected %0b at (%0d,%0d)",
                                         is_last, want.is_last, want.x, want.y));
         end
      endtask
   endclass

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_start_x;
   coord_type req_start_y;
   coord_type req_end_x;
   coord_type req_end_y;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_cell_x;
   coord_type rsp_cell_y;
   logic      rsp_last_cell;

   cell_scoreboard_type sb = new();
   int                  cycle_count;
   int                  burst_left;
   drain_mode_type      drain_mode;
   int                  drain_run;
   int                  drain_phase;

   bresenham_line_rasterizer #(
      .COORD_BITS(CB)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_cell_x   (rsp_cell_x),
      .rsp_cell_y   (rsp_cell_y),
      .rsp_last_cell(rsp_last_cell)
   );

   always #10 clock = ~clock;

   // Monitor both channels at the rising edge. Note the segment before checking
   // cells so an accepted segment's expectations exist before any of its cells.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d cells outstanding",
                  cycle_count, sb.pending());
         $display("Test completed with failures");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_segment(req_start_x, req_start_y, req_end_x, req_end_y);
         if (rsp_valid && rsp_ready)
            sb.check_cell(rsp_cell_x, rsp_cell_y, rsp_last_cell);
      end
   end

   // Receiver back-pressure: switch between free flow, random stalls and a
   // fixed throttle, each for a random stretch, so stalls land on every phase.
   always @(negedge clock) begin
      if (drain_run == 0) begin
         drain_mode = drain_mode_type'($urandom_range(DRAIN_FREE, DRAIN_THROTTLE));
         drain_run  = $urandom_range(20, 150);
         drain_phase = 0;
      end
      drain_run--;
      drain_phase++;
      case (drain_mode)
         DRAIN_FREE: begin
            rsp_ready = 1'b1;
         end
         DRAIN_RANDOM: begin
            rsp_ready = ($urandom_range(0, 2) != 0);
         end
         default: begin
            rsp_ready = (drain_phase % 5 == 0);
         end
      endcase
   end

   function automatic int clamp_coord(int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // Present one segment at the falling edge and hold it until accepted.
   // Between bursts drop valid for a random gap.
   task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_start_x = coord_type'(sx);
      req_start_y = coord_type'(sy);
      req_end_x   = coord_type'(ex);
      req_end_y   = coord_type'(ey);
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Hold off the sender until every predicted cell has been checked.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int kind, sx, sy, ex, ey, len;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      rsp_ready   = 1'b0;
      cycle_count = 0;
      burst_left  = 0;
      drain_run   = 0;
      drain_phase = 0;
      drain_mode  = DRAIN_FREE;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed segments: single cells, full-range axis lines both ways,
      // equal-span diagonals, steep and shallow slopes with both minor directions.
      send_segment(0, 0, 0, 0);
      send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_segment(COORD_MIN, 0, COORD_MAX, 0);
      send_segment(COORD_MAX, 5, COORD_MIN, 5);
      send_segment(3, COORD_MIN, 3, COORD_MAX);
      send_segment(-7, COORD_MAX, -7, COORD_MIN);
      send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      send_segment(0, 0, COORD_MAX, 10);
      send_segment(0, 0, COORD_MAX, -10);
      send_segment(5, -20, -3, 30);
      send_segment(5, 30, -3, -20);
      send_segment(-10, -10, 20, -9);
      send_segment(-1, 0, 0, COORD_MAX);
      send_segment(10, 10, 11, 11);
      send_segment(10, 10, 11, 10);
      send_segment(21, -5, -21, 5);
      send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX - 1);
      hold_until_drained();

      // Random segments: short ones anywhere on the grid most often, plus full-range
      // endpoints, axis-aligned and diagonal runs, and near-degenerate pairs.
      for (int i = 0; i < RANDOM_SEGS; i++) begin
         kind = $urandom_range(0, 99);
         sx   = $urandom_range(0, (1 << CB) - 1) + COORD_MIN;
         sy   = $urandom_range(0, (1 << CB) - 1) + COORD_MIN;
         if (kind < 30) begin
            ex = $urandom_range(0, (1 << CB) - 1) + COORD_MIN;
            ey = $urandom_range(0, (1 << CB) - 1) + COORD_MIN;
         end else if (kind < 70) begin
            ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
            ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
         end else if (kind < 90) begin
            len = int'($urandom_range(0, 63)) - 32;
            case ($urandom_range(0, 2))
               0: begin ex = clamp_coord(sx + len); ey = sy; end
               1: begin ex = sx; ey = clamp_coord(sy + len); end
               default: begin
                  ex = clamp_coord(sx + len);
                  ey = clamp_coord(sy + (($urandom_range(0, 1) != 0) ? len : -len));
               end
            endcase
         end else begin
            ex = clamp_coord(sx + int'($urandom_range(0, 2)) - 1);
            ey = clamp_coord(sy + int'($urandom_range(0, 2)) - 1);
         end
         send_segment(sx, sy, ex, ey);
         if (i == RANDOM_SEGS / 2) hold_until_drained();
      end

      // Drop valid, drain the remaining cells, then idle to catch stray output.
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Rasterized %0d segments into %0d cells (%0d steep, %0d reversed, %0d single-cell)",
               sb.segments, sb.cells_checked, sb.steep_segs, sb.reversed_segs,
               sb.single_cells);
      $display("Back-pressure mixed free flow, random stalls and throttling; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : bresenham_line_rasterizer_tb

`default_nettype wire
